/* src/badge_credential_table_unit_defines.svh */
// badge_credential_table_unit_defines.svh: assertion macros for the badge credential table
// no dependencies; included by the files that carry concurrent assertions
`ifndef BADGE_CREDENTIAL_TABLE_UNIT_DEFINES_SVH
`define BADGE_CREDENTIAL_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define BCT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bct assertion failed");

// next-cycle implication
`define BCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bct assertion failed");

`else

`define BCT_ASSERT_NOW(label, clk, rst, ante, cons)
`define BCT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* src/bct_pkg.sv */
// bct_pkg: types, codes and helpers of the badge credential table
// no dependencies; used by bct_cell and badge_credential_table_unit
`timescale 1ns / 1ps

package bct_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int SLOT_W = 4;
   localparam int KEY_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
   localparam int UID_BYTES = 7;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_LOOKUP = 3'd1;
   localparam logic [2:0] OP_SETACT = 3'd2;
   localparam logic [2:0] OP_ACCESS = 3'd3;
   localparam logic [2:0] OP_DELETE = 3'd4;

   localparam logic [1:0] PROF_ADMIN = 2'd0;
   localparam logic [1:0] PROF_OWNER = 2'd1;
   localparam logic [1:0] PROF_TEMP  = 2'd2;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_MISS = 2'd2;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [3:0]  slot;
      logic [55:0] uid;
      logic [2:0]  uid_len;
      logic [1:0]  profile;
      logic        active_flag;
      logic [15:0] access_count;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  found_slot;
      logic [1:0]  entry_profile_out;
      logic        entry_active_out;
      logic [15:0] remaining_out;
      logic        entry_deleted;
      logic [4:0]  used_entries;
   } rsp_type;

   typedef struct packed {
      logic [55:0] uid;
      logic [2:0]  len;
      logic [1:0]  profile;
      logic        active;
      logic [15:0] remaining;
   } entry_type;

   // transaction travelling down the cell chain with its running result
   typedef struct packed {
      logic             valid;
      req_type          req;
      logic             hit;
      logic [CNT_W-1:0] hit_idx;
      entry_type        ent;
      logic             del;
   } probe_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             shift_en;
      logic [CNT_W-1:0] shift_idx;
   } cell_ctl_type;

   // keeps the first len bytes of a uid
   function automatic logic [55:0] uid_mask(input logic [2:0] len);
      logic [55:0] mask;
      mask = '0;
      for (int b = 0; b < UID_BYTES; b++) begin
         if (3'(b) < len) begin
            mask[8*b +: 8] = 8'hFF;
         end
      end
      return mask;
   endfunction

endpackage

/* src/bct_cell.sv */
// bct_cell: one table entry with its slice of the search and update logic
// depends on bct_pkg; instantiated in a chain by badge_credential_table_unit
`timescale 1ns / 1ps

module bct_cell
   import bct_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] cell_index,
   input  cell_ctl_type     ctl,
   input  probe_type        probe_i,
   input  entry_type        next_entry,
   output probe_type        probe_o,
   output entry_type        entry_o
);

   entry_type entry_ff, entry_in;
   probe_type probe_ff, probe_in;
   logic      occupied;
   logic      slot_match;
   logic      uid_match;
   logic [15:0] rem_dec;

   assign occupied   = cell_index < ctl.count;
   assign slot_match = occupied && (KEY_W'(cell_index) == KEY_W'(probe_i.req.slot));
   assign uid_match  = (entry_ff.len == probe_i.req.uid_len) &&
                       (entry_ff.uid == probe_i.req.uid);
   assign rem_dec    = (entry_ff.remaining != 16'd0) ? entry_ff.remaining - 16'd1
                                                     : entry_ff.remaining;

   always_comb begin
      entry_in = entry_ff;
      probe_in = probe_i;
      priority if (ctl.shift_en && (cell_index >= ctl.shift_idx)) begin
         // compaction: take the neighbor's entry
         entry_in = next_entry;
      end else if (probe_i.valid) begin
         unique case (probe_i.req.opcode)
            OP_INSERT: begin
               if (cell_index == ctl.count) begin
                  entry_in.uid       = probe_i.req.uid;
                  entry_in.len       = probe_i.req.uid_len;
                  entry_in.profile   = probe_i.req.profile;
                  entry_in.active    = probe_i.req.active_flag;
                  entry_in.remaining = probe_i.req.access_count;
                  probe_in.hit       = 1'b1;
                  probe_in.hit_idx   = cell_index;
                  probe_in.ent       = entry_in;
               end
            end
            OP_LOOKUP: begin
               // first match wins, later cells leave it alone
               if (!probe_i.hit && occupied && uid_match) begin
                  probe_in.hit     = 1'b1;
                  probe_in.hit_idx = cell_index;
                  probe_in.ent     = entry_ff;
               end
            end
            OP_SETACT: begin
               if (slot_match) begin
                  entry_in.active  = probe_i.req.active_flag;
                  probe_in.hit     = 1'b1;
                  probe_in.hit_idx = cell_index;
                  probe_in.ent     = entry_in;
               end
            end
            OP_ACCESS: begin
               if (slot_match) begin
                  if (entry_ff.active && (entry_ff.profile == PROF_OWNER ||
                                          entry_ff.profile == PROF_TEMP)) begin
                     entry_in.remaining = rem_dec;
                     if (rem_dec == 16'd0) begin
                        if (entry_ff.profile == PROF_OWNER) begin
                           entry_in.active = 1'b0;
                        end else begin
                           probe_in.del = 1'b1;
                        end
                     end
                  end
                  probe_in.hit     = 1'b1;
                  probe_in.hit_idx = cell_index;
                  probe_in.ent     = entry_in;
               end
            end
            OP_DELETE: begin
               if (slot_match) begin
                  probe_in.hit     = 1'b1;
                  probe_in.hit_idx = cell_index;
                  probe_in.ent     = entry_ff;
                  probe_in.del     = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
         entry_ff <= '0;
      end else begin
         probe_ff <= probe_in;
         entry_ff <= entry_in;
      end
   end

   assign probe_o = probe_ff;
   assign entry_o = entry_ff;

endmodule

/* src/badge_credential_table_unit.sv */
// badge_credential_table_unit: top level of the badge credential table
// depends on bct_pkg, bct_cell and badge_credential_table_unit_defines.svh
//
// usage:
//   req_valid/req_stall/req_data carry one operation per transaction (insert,
//   lookup, set active, access, delete); rsp_valid/rsp_stall/rsp_data return
//   exactly one result per request, in order.
//   each request travels down a chain of TABLE_DEPTH cells, one cell per cycle;
//   every cell holds one entry, compares or updates it and passes the running
//   result on. a delete or an expiring temporary badge adds a compaction
//   state in which the removed cell and every later cell take the entry of
//   its upper neighbor. a request passes the input register and the cell
//   chain, then the result register (and the compaction state, if any), and
//   its result is then loaded into the output register; one request is in
//   flight at a time, so a new request is taken only after that load.
//   req_stall is high during reset and while a request is in flight. a finished
//   result waits in the output register while rsp_stall is high and the next
//   request may already run; the following result is held back until it frees.
//   synchronous reset empties the table (count zero, all entries inactive)
//   and drops any transaction in flight; no clearing pass is needed.
`timescale 1ns / 1ps
`include "badge_credential_table_unit_defines.svh"

module badge_credential_table_unit
   import bct_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_RUN   = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   probe_type        probe0_ff, probe0_in;
   probe_type        res_ff, res_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_next;
   cell_ctl_type     ctl;
   logic             accept;
   logic             rsp_free;

   probe_type probe_w [TABLE_DEPTH+1];
   entry_type ent_w   [TABLE_DEPTH];

   assign req_stall = reset || (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign ctl.count     = count_ff;
   assign ctl.shift_en  = (state_ff == S_SHIFT);
   assign ctl.shift_idx = res_ff.hit_idx;

   always_comb begin
      probe0_in         = '0;
      probe0_in.valid   = accept;
      probe0_in.req     = req_data;
      probe0_in.req.uid = req_data.uid & uid_mask(req_data.uid_len);
   end

   assign probe_w[0] = probe0_ff;

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      entry_type nbr;
      if (k < TABLE_DEPTH - 1) begin : g_mid
         assign nbr = ent_w[k+1];
      end else begin : g_last
         assign nbr = '0;
      end
      bct_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (CNT_W'(k)),
         .ctl        (ctl),
         .probe_i    (probe_w[k]),
         .next_entry (nbr),
         .probe_o    (probe_w[k+1]),
         .entry_o    (ent_w[k])
      );
   end

   // result of the finished transaction
   always_comb begin
      logic [1:0] st;
      st       = STAT_MISS;
      rsp_next = '0;
      unique case (res_ff.req.opcode)
         OP_INSERT: st = res_ff.hit ? STAT_OK : STAT_FULL;
         OP_LOOKUP, OP_SETACT, OP_ACCESS, OP_DELETE: st = res_ff.hit ? STAT_OK : STAT_MISS;
         default: st = STAT_MISS;
      endcase
      rsp_next.status       = st;
      rsp_next.used_entries = 5'(count_ff);
      if (st == STAT_OK) begin
         if (res_ff.req.opcode == OP_INSERT || res_ff.req.opcode == OP_LOOKUP) begin
            rsp_next.found_slot = 4'(res_ff.hit_idx);
         end
         rsp_next.entry_profile_out = res_ff.ent.profile;
         rsp_next.entry_active_out  = res_ff.ent.active;
         rsp_next.remaining_out     = res_ff.ent.remaining;
         rsp_next.entry_deleted     = res_ff.del;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (probe_w[TABLE_DEPTH].valid) begin
               res_in = probe_w[TABLE_DEPTH];
               if (probe_w[TABLE_DEPTH].hit &&
                   probe_w[TABLE_DEPTH].req.opcode == OP_INSERT) begin
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = probe_w[TABLE_DEPTH].del ? S_SHIFT : S_DONE;
            end
         end
         S_SHIFT: begin
            count_in = count_ff - CNT_W'(1);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_in       = rsp_next;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         probe0_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         probe0_ff    <= probe0_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `BCT_ASSERT_NOW(a_count_max, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH))
   `BCT_ASSERT_NEXT(a_accept_starts, clock, reset, accept, state_ff == S_RUN && probe0_ff.valid)
   `BCT_ASSERT_NOW(a_exit_in_run, clock, reset, probe_w[TABLE_DEPTH].valid, state_ff == S_RUN)
   `BCT_ASSERT_NOW(a_shift_on_del, clock, reset, state_ff == S_SHIFT, res_ff.del && res_ff.hit)
   `BCT_ASSERT_NEXT(a_shift_count, clock, reset, state_ff == S_SHIFT, count_ff == $past(count_ff) - CNT_W'(1))

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking testbench of badge_credential_table_unit
// depends on bct_pkg and the badge_credential_table_unit rtl; predicts each result
// from a shadow credential table and checks it against the dut in order
`timescale 1ns / 1ps

module tb_top;
   import bct_pkg::*;

   localparam int          CYCLE_LIMIT  = 800000;
   localparam int          DRAIN_CYCLES = TABLE_DEPTH + 8;
   localparam int          RANDOM_ITEMS = 920;
   localparam logic [1:0]  PROF_UNUSED  = 2'd3;
   localparam logic [55:0] UID_ONES     = {56{1'b1}};

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   badge_credential_table_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // shadow copy of the credential table
   logic [55:0] cred_uid  [TABLE_DEPTH];
   logic [2:0]  cred_len  [TABLE_DEPTH];
   logic [1:0]  cred_prof [TABLE_DEPTH];
   logic        cred_act  [TABLE_DEPTH];
   logic [15:0] cred_rem  [TABLE_DEPTH];
   int          cred_count = 0;

   rsp_type     pending_results [$];
   rsp_type     expected_result;
   int          err_count   = 0;
   int          cycle_count = 0;
   bit          calm        = 1'b0;   // no idling on either side while set
   int          stall_left  = 0;
   int          flow_left   = 0;

   function automatic logic [55:0] len_mask(logic [2:0] len);
      return UID_ONES >> (8 * (7 - int'(len)));
   endfunction

   function automatic rsp_type predict_credential_result(req_type r);
      rsp_type     res;
      logic [55:0] key;
      int          s;
      bit          remove;
      res = '0;
      res.status = STAT_MISS;
      key = r.uid & len_mask(r.uid_len);
      s = int'(r.slot);
      remove = 1'b0;
      case (r.opcode)
         OP_INSERT: begin
            if (cred_count >= TABLE_DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               cred_uid[cred_count]  = key;
               cred_len[cred_count]  = r.uid_len;
               cred_prof[cred_count] = r.profile;
               cred_act[cred_count]  = r.active_flag;
               cred_rem[cred_count]  = r.access_count;
               res.status            = STAT_OK;
               res.found_slot        = 4'(cred_count);
               res.entry_profile_out = r.profile;
               res.entry_active_out  = r.active_flag;
               res.remaining_out     = r.access_count;
               cred_count++;
            end
         end
         OP_LOOKUP: begin
            for (int i = 0; i < cred_count; i++) begin
               if (cred_len[i] == r.uid_len && cred_uid[i] == key) begin
                  res.status            = STAT_OK;
                  res.found_slot        = 4'(i);
                  res.entry_profile_out = cred_prof[i];
                  res.entry_active_out  = cred_act[i];
                  res.remaining_out     = cred_rem[i];
                  break;
               end
            end
         end
         OP_SETACT, OP_ACCESS, OP_DELETE: begin
            if (s < cred_count) begin
               res.status = STAT_OK;
               if (r.opcode == OP_SETACT) begin
                  cred_act[s] = r.active_flag;
               end else if (r.opcode == OP_DELETE) begin
                  remove = 1'b1;
               end else if (cred_act[s] &&
                            (cred_prof[s] == PROF_OWNER || cred_prof[s] == PROF_TEMP)) begin
                  if (cred_rem[s] != 16'd0) begin
                     cred_rem[s]--;
                  end
                  // an exhausted owner goes inactive, an exhausted temporary goes away
                  if (cred_rem[s] == 16'd0) begin
                     if (cred_prof[s] == PROF_OWNER) begin
                        cred_act[s] = 1'b0;
                     end else begin
                        remove = 1'b1;
                     end
                  end
               end
               res.entry_profile_out = cred_prof[s];
               res.entry_active_out  = cred_act[s];
               res.remaining_out     = cred_rem[s];
               res.entry_deleted     = remove;
               if (remove) begin
                  for (int i = s; i < cred_count - 1; i++) begin
                     cred_uid[i]  = cred_uid[i + 1];
                     cred_len[i]  = cred_len[i + 1];
                     cred_prof[i] = cred_prof[i + 1];
                     cred_act[i]  = cred_act[i + 1];
                     cred_rem[i]  = cred_rem[i + 1];
                  end
                  cred_len[cred_count - 1] = '0;
                  cred_act[cred_count - 1] = 1'b0;
                  cred_count--;
               end
            end
         end
         default: ;
      endcase
      res.used_entries = 5'(cred_count);
      return res;
   endfunction

   function automatic req_type make_req(logic [2:0] op, logic [3:0] slot, logic [55:0] uid,
                                        logic [2:0] len, logic [1:0] prof, logic act,
                                        logic [15:0] cnt);
      req_type r;
      r.opcode       = op;
      r.slot         = slot;
      r.uid          = uid;
      r.uid_len      = len;
      r.profile      = prof;
      r.active_flag  = act;
      r.access_count = cnt;
      return r;
   endfunction

   function automatic req_type random_request(int insert_pct);
      req_type     r;
      int          q;
      int          e;
      int          copy_pct;
      logic [55:0] m;
      r.uid[31:0]  = $urandom;
      r.uid[55:32] = 24'($urandom);
      r.uid_len    = 3'($urandom_range(0, 7));
      r.profile    = ($urandom_range(0, 15) == 0) ? PROF_UNUSED : 2'($urandom_range(0, 2));
      r.active_flag = ($urandom_range(0, 4) != 0);
      r.access_count = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 3))
                                                 : 16'($urandom_range(0, 65535));
      r.slot = (cred_count > 0 && $urandom_range(0, 7) != 0) ?
               4'($urandom_range(0, cred_count - 1)) : 4'($urandom_range(0, 15));
      copy_pct = 75;
      if ($urandom_range(0, 99) < insert_pct) begin
         r.opcode = OP_INSERT;
         copy_pct = 20;
      end else begin
         q = $urandom_range(0, 99);
         if (q < 30) begin
            r.opcode = OP_LOOKUP;
         end else if (q < 45) begin
            r.opcode = OP_SETACT;
         end else if (q < 80) begin
            r.opcode = OP_ACCESS;
         end else if (q < 96) begin
            r.opcode = OP_DELETE;
         end else begin
            r.opcode = 3'($urandom_range(int'(OP_DELETE) + 1, 7));
         end
      end
      // reuse a stored key, with garbage above its length
      if (cred_count > 0 && $urandom_range(0, 99) < copy_pct) begin
         e = $urandom_range(0, cred_count - 1);
         m = len_mask(cred_len[e]);
         r.uid_len = cred_len[e];
         r.uid = (cred_uid[e] & m) | (r.uid & ~m);
      end
      return r;
   endfunction

   task automatic issue_request(req_type r);
      int g;
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(predict_credential_result(r));
      g = $urandom_range(0, 99);
      if (calm || g < 60) begin
         gap = 0;
      end else if (g < 95) begin
         gap = $urandom_range(1, 4);
      end else begin
         gap = $urandom_range(20, 80);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic test_directed();
      // empty table, unknown opcodes
      issue_request(make_req(OP_LOOKUP, 4'd0, '0, 3'd0, PROF_ADMIN, 1'b0, '0));
      issue_request(make_req(OP_ACCESS, 4'd0, '0, 3'd0, PROF_ADMIN, 1'b0, '0));
      issue_request(make_req(OP_DELETE, 4'd15, UID_ONES, 3'd7, PROF_TEMP, 1'b1, '1));
      issue_request(make_req(OP_SETACT, 4'd0, '0, 3'd0, PROF_ADMIN, 1'b1, '0));
      for (int op = int'(OP_DELETE) + 1; op < 8; op++) begin
         issue_request(make_req(3'(op), 4'd15, UID_ONES, 3'd7, PROF_UNUSED, 1'b1, '1));
      end
      // inserts at the field extremes, with a duplicate key in slot 3
      issue_request(make_req(OP_INSERT, 4'd0, UID_ONES, 3'd0, PROF_ADMIN, 1'b1, 16'hFFFF));
      issue_request(make_req(OP_INSERT, 4'd0, UID_ONES, 3'd7, PROF_OWNER, 1'b1, 16'd1));
      issue_request(make_req(OP_INSERT, 4'd0, 56'hA5A5A5A5123456, 3'd3, PROF_TEMP, 1'b1,
                             16'd1));
      issue_request(make_req(OP_INSERT, 4'd0, 56'h123456, 3'd3, PROF_UNUSED, 1'b1, 16'd5));
      issue_request(make_req(OP_INSERT, 4'd0, 56'h3456, 3'd2, PROF_TEMP, 1'b1, 16'd0));
      // lookups: first match, length mismatch, empty uid
      issue_request(make_req(OP_LOOKUP, 4'd0, 56'hFFFFFFFF123456, 3'd3, PROF_ADMIN, 1'b0,
                             '0));
      issue_request(make_req(OP_LOOKUP, 4'd0, 56'h123456, 3'd4, PROF_ADMIN, 1'b0, '0));
      issue_request(make_req(OP_LOOKUP, 4'd0, 56'h5A5A5A, 3'd0, PROF_ADMIN, 1'b0, '0));
      // accesses: admin, owner running out, inactive owner, unused profile,
      // temporary running out, temporary already at zero
      issue_request(make_req(OP_ACCESS, 4'd0, '0, 3'd0, PROF_ADMIN, 1'b0, '0));
      issue_request(make_req(OP_ACCESS, 4'd1, '0, 3'd0, PROF_ADMIN, 1'b0, '0));
      issue_request(make_req(OP_ACCESS, 4'd1, '0, 3'd0, PROF_ADMIN, 1'b0, '0));
      issue_request(make_req(OP_ACCESS, 4'd3, '0, 3'd0, PROF_ADMIN, 1'b0, '0));
      issue_request(make_req(OP_ACCESS, 4'd2, '0, 3'd0, PROF_ADMIN, 1'b0, '0));
      issue_request(make_req(OP_ACCESS, 4'd3, '0, 3'd0, PROF_ADMIN, 1'b0, '0));
      // set active on a later slot, then an owner with nothing left
      issue_request(make_req(OP_SETACT, 4'd1, '0, 3'd0, PROF_ADMIN, 1'b1, '0));
      issue_request(make_req(OP_ACCESS, 4'd1, '0, 3'd0, PROF_ADMIN, 1'b0, '0));
      issue_request(make_req(OP_SETACT, 4'd2, '0, 3'd0, PROF_ADMIN, 1'b0, '0));
      // slot at the count is out of range, then compaction from the front
      issue_request(make_req(OP_DELETE, 4'd3, '0, 3'd0, PROF_ADMIN, 1'b0, '0));
      issue_request(make_req(OP_DELETE, 4'd0, '0, 3'd0, PROF_ADMIN, 1'b0, '0));
   endtask

   task automatic test_table_full();
      req_type r;
      while (cred_count < TABLE_DEPTH) begin
         issue_request(random_request(100));
      end
      issue_request(random_request(100));
      r = make_req(OP_LOOKUP, 4'd0, cred_uid[TABLE_DEPTH - 1], cred_len[TABLE_DEPTH - 1],
                   PROF_ADMIN, 1'b0, '0);
      issue_request(r);
      issue_request(make_req(OP_ACCESS, 4'(TABLE_DEPTH - 1), '0, 3'd0, PROF_ADMIN, 1'b0, '0));
      issue_request(make_req(OP_DELETE, 4'd0, '0, 3'd0, PROF_ADMIN, 1'b0, '0));
      issue_request(random_request(100));
      issue_request(random_request(100));
   endtask

   task automatic test_random();
      int insert_pct;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // alternate filling and draining phases, some of them without idling
         if (n % 60 == 0) begin
            insert_pct = ((n / 60) % 3 == 0) ? 60 : 25;
            calm = ((n / 60) % 5 == 3);
         end
         issue_request(random_request(insert_pct));
      end
      calm = 1'b0;
   endtask

   // result side back-pressure: stall bursts separated by free-flowing stretches
   always @(negedge clock) begin
      if (calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (flow_left > 0) begin
         flow_left--;
         rsp_stall <= 1'b0;
      end else begin
         stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(0, 3);
         flow_left  = $urandom_range(0, 30);
         rsp_stall <= 1'b0;
      end
   end

   function automatic void compare_field(string name, logic [15:0] exp_val,
                                         logic [15:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
         err_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result transaction with nothing pending, expected none actual %h",
                     $time, rsp_data);
            err_count++;
         end else begin
            expected_result = pending_results.pop_front();
            compare_field("status", 16'(expected_result.status), 16'(rsp_data.status));
            compare_field("found_slot", 16'(expected_result.found_slot),
                          16'(rsp_data.found_slot));
            compare_field("entry_profile_out", 16'(expected_result.entry_profile_out),
                          16'(rsp_data.entry_profile_out));
            compare_field("entry_active_out", 16'(expected_result.entry_active_out),
                          16'(rsp_data.entry_active_out));
            compare_field("remaining_out", expected_result.remaining_out,
                          rsp_data.remaining_out);
            compare_field("entry_deleted", 16'(expected_result.entry_deleted),
                          16'(rsp_data.entry_deleted));
            compare_field("used_entries", 16'(expected_result.used_entries),
                          16'(rsp_data.used_entries));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         cred_uid[i]  = '0;
         cred_len[i]  = '0;
         cred_prof[i] = '0;
         cred_act[i]  = 1'b0;
         cred_rem[i]  = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_table_full();
      test_random();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+src
src/bct_pkg.sv
src/bct_cell.sv
src/badge_credential_table_unit.sv
tb/tb_top.sv
